[rtl/ccpm_pkg.sv]
package ccpm_pkg;

    localparam int ANGLE_BITS = 24;
    localparam int FRAC_BITS  = 16;

    localparam int CORDIC_N = 24;
    localparam int IDX_W    = 5;
    localparam int VW       = 36;
    localparam int RW       = 34;
    localparam int FW       = FRAC_BITS + 4;
    localparam int TW       = 32 + FW - FRAC_BITS;
    localparam int ZW       = 48;

    localparam int ONE_F       = 1 << FRAC_BITS;
    localparam int HALF_F      = 1 << (FRAC_BITS - 1);
    localparam int NINE_TENTHS = (9 * ONE_F + 5) / 10;
    localparam int ONE_TENTH   = (ONE_F + 5) / 10;
    localparam int CORDIC_K    = 652032874;

    localparam int VEC_LAT   = CORDIC_N;
    localparam int TRIG_LAT  = CORDIC_N + 1;
    localparam int FRONT_LAT = VEC_LAT + 1 + TRIG_LAT;
    localparam int PROD_LAT  = 8;
    localparam int LAT       = FRONT_LAT + PROD_LAT;
    localparam int SB_DEPTH  = LAT - 1;

    typedef logic [ANGLE_BITS-1:0]        angle_t;
    typedef logic signed [FRAC_BITS+1:0]  unit_t;
    typedef logic signed [FW-1:0]         frac_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [31:0]   z;
        logic [1:0]           q;
    } rot_t;

    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] src_z;
        logic [15:0]        rand_frac;
    } sb_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic signed [31:0] atan_val(input logic [IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10680862;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // fixed-point product, rounded half up
    function automatic frac_t mulr_f(input frac_t a, input frac_t b);
        logic signed [2*FW-1:0] p;
        p = (2*FW)'(a) * (2*FW)'(b);
        p = p + (2*FW)'(HALF_F);
        return frac_t'(p >>> FRAC_BITS);
    endfunction

endpackage

[rtl/ccpm_if.sv]
interface ccpm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [15:0]        rand_frac;

    modport source (output valid, src_x, src_y, src_z, acc_x, acc_y, acc_z, rand_frac,
                    input ready);
    modport sink (input valid, src_x, src_y, src_z, acc_x, acc_y, acc_z, rand_frac,
                  output ready);
endinterface

interface ccpm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;

    modport source (output valid, new_x, new_y, new_z, input ready);
    modport sink (input valid, new_x, new_y, new_z, output ready);
endinterface

[rtl/ccpm_vec_cell.sv]
module ccpm_vec_cell (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ccpm_pkg::IDX_W-1:0]      idx,
    input  ccpm_pkg::vec_t                  d_in,
    output ccpm_pkg::vec_t                  d_out
);
    import ccpm_pkg::*;

    vec_t                 d_next;
    vec_t                 d_reg;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        dx = d_in.y >>> idx;
        dy = d_in.x >>> idx;
        d_next = d_in;
        if (d_in.y > 0)
        begin
            d_next.x   = d_in.x + dx;
            d_next.y   = d_in.y - dy;
            d_next.ang = d_in.ang + atan_val(idx);
        end
        else
        begin
            d_next.x   = d_in.x - dx;
            d_next.y   = d_in.y + dy;
            d_next.ang = d_in.ang - atan_val(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

[rtl/ccpm_rot_cell.sv]
module ccpm_rot_cell (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ccpm_pkg::IDX_W-1:0]      idx,
    input  ccpm_pkg::rot_t                  d_in,
    output ccpm_pkg::rot_t                  d_out
);
    import ccpm_pkg::*;

    rot_t                 d_next;
    rot_t                 d_reg;
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;

    always_comb
    begin
        dx = d_in.y >>> idx;
        dy = d_in.x >>> idx;
        d_next = d_in;
        if (d_in.z >= 0)
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - atan_val(idx);
        end
        else
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + atan_val(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

[rtl/ccpm_trig.sv]
module ccpm_trig (
    input  logic                clk,
    input  logic                en,
    input  ccpm_pkg::angle_t    ang,
    output ccpm_pkg::unit_t     sn,
    output ccpm_pkg::unit_t     cs
);
    import ccpm_pkg::*;

    localparam int SH = 30 - FRAC_BITS;

    rot_t        stg [CORDIC_N+1];
    logic [31:0] th;
    logic [31:0] th_bias;
    logic [1:0]  quad;
    unit_t       c_u;
    unit_t       s_u;
    unit_t       sn_next;
    unit_t       cs_next;
    unit_t       sn_reg;
    unit_t       cs_reg;

    function automatic unit_t round_clamp(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        r = (v + RW'(1 << (SH - 1))) >>> SH;
        if (r > RW'(ONE_F))
            return unit_t'(ONE_F);
        if (r < -RW'(ONE_F))
            return -unit_t'(ONE_F);
        return unit_t'(r);
    endfunction

    // fold to the nearest quadrant axis
    always_comb
    begin
        th      = 32'(ang) << (32 - ANGLE_BITS);
        th_bias = th + 32'h2000_0000;
        quad    = th_bias[31:30];
        stg[0].x = RW'(CORDIC_K);
        stg[0].y = '0;
        stg[0].z = signed'(th - {quad, 30'd0});
        stg[0].q = quad;
    end

    for (genvar g = 0; g < CORDIC_N; g++)
    begin : g_cell
        ccpm_rot_cell u_cell (
            .clk   (clk),
            .en    (en),
            .idx   (IDX_W'(g)),
            .d_in  (stg[g]),
            .d_out (stg[g+1])
        );
    end

    always_comb
    begin
        c_u = round_clamp(stg[CORDIC_N].x);
        s_u = round_clamp(stg[CORDIC_N].y);
        case (stg[CORDIC_N].q)
            2'd0:
            begin
                cs_next = c_u;
                sn_next = s_u;
            end
            2'd1:
            begin
                cs_next = -s_u;
                sn_next = c_u;
            end
            2'd2:
            begin
                cs_next = -c_u;
                sn_next = -s_u;
            end
            default:
            begin
                cs_next = s_u;
                sn_next = -c_u;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

[rtl/cannabis_curve_point_map.sv]
// cannabis curve point map
// pt_in takes one word per cycle: the transformed point, the accumulator
// point and a random fraction. pt_out gives one word per input word, in
// order: the accumulator plus weight times the curve point, saturated.
// a result passes through 58 register stages; throughput is one word per
// cycle, set by a chain of 24 vectoring cordic cells followed by five
// parallel chains of 24 rotation cordic cells and an 8-stage product pipe.
// when pt_out stalls the whole pipe holds, so pt_in.ready follows
// pt_out.ready while a result waits; bubbles drain without a stall.
// the apb port holds weight (addr 0x0, signed q16.16, reset 1.0) and
// fill_mode (addr 0x4, bit 0, reset 1); write them only while idle.
// reset clears the valid line and resets the apb registers; no clearing pass is needed.
module cannabis_curve_point_map (
    input  logic          clk,
    input  logic          rst_n,
    ccpm_in_if.sink       pt_in,
    ccpm_out_if.source    pt_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ccpm_pkg::*;

    localparam logic REG_WEIGHT = 1'b0;
    localparam logic REG_FILL   = 1'b1;
    localparam angle_t QUARTER  = angle_t'(1) << (ANGLE_BITS - 2);

    logic signed [31:0] weight_reg;
    logic               fill_reg;
    logic               en;
    logic               accept;
    logic [LAT-1:0]     vld_reg;
    sb_t                sb_reg [SB_DEPTH];
    vec_t               vstg [CORDIC_N+1];
    angle_t             a0;
    angle_t             a1_reg, a8_reg, a24_reg, a200_reg, aq_reg;
    unit_t              s1, c1, s8, c8, s24, c24, s200, c200, sq, cq;

    frac_t p1_f1_reg, p1_f2_reg, p1_f3_reg, p1_f4_reg;
    unit_t p1_sq_reg, p1_cq_reg;
    frac_t p2_m_reg, p2_f3_reg, p2_f4_reg;
    unit_t p2_sq_reg, p2_cq_reg;
    frac_t p3_m_reg, p3_f4_reg;
    unit_t p3_sq_reg, p3_cq_reg;
    frac_t p4_r_reg;
    unit_t p4_sq_reg, p4_cq_reg;
    frac_t p5_r_next, p5_r_reg;
    unit_t p5_sq_reg, p5_cq_reg;
    frac_t p6_nx_reg, p6_ny_reg;
    logic signed [TW-1:0] p7_tx_next, p7_ty_next, p7_tx_reg, p7_ty_reg;
    logic signed [ZW-1:0] p7_tz_next, p7_tz_reg;
    logic signed [31:0]   p8_x_next, p8_y_next, p8_z_next;
    logic signed [31:0]   p8_x_reg, p8_y_reg, p8_z_reg;

    logic signed [FW+16:0]   pr;
    logic signed [32+FW-1:0] px, py;
    logic signed [63:0]      pz;
    logic signed [TW:0]      sx, sy;
    logic signed [ZW:0]      sz;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FILL) ? {31'd0, fill_reg} : weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 32'sd65536;
            fill_reg   <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_WEIGHT: weight_reg <= pwdata;
                REG_FILL:   fill_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // flow control: the whole pipe advances together
    assign en           = !vld_reg[LAT-1] || pt_out.ready;
    assign pt_in.ready  = en;
    assign accept       = pt_in.valid && en;
    assign pt_out.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= '{acc_x: pt_in.acc_x, acc_y: pt_in.acc_y, acc_z: pt_in.acc_z,
                           src_z: pt_in.src_z, rand_frac: pt_in.rand_frac};
            for (int k = 1; k < SB_DEPTH; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // angle of (src_y, src_x), left half folded over
    always_comb
    begin
        vstg[0].x    = VW'(pt_in.src_y);
        vstg[0].y    = VW'(pt_in.src_x);
        vstg[0].ang  = '0;
        vstg[0].zero = (pt_in.src_x == 0) && (pt_in.src_y == 0);
        if (pt_in.src_y < 0)
        begin
            vstg[0].x   = -VW'(pt_in.src_y);
            vstg[0].y   = -VW'(pt_in.src_x);
            vstg[0].ang = 32'h8000_0000;
        end
    end

    for (genvar g = 0; g < CORDIC_N; g++)
    begin : g_vec
        ccpm_vec_cell u_cell (
            .clk   (clk),
            .en    (en),
            .idx   (IDX_W'(g)),
            .d_in  (vstg[g]),
            .d_out (vstg[g+1])
        );
    end

    assign a0 = vstg[CORDIC_N].zero ? '0 : vstg[CORDIC_N].ang[31 -: ANGLE_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a0;
            a8_reg   <= a0 << 3;
            a24_reg  <= (a0 << 3) + (a0 << 4);
            a200_reg <= (a0 << 7) + (a0 << 6) + (a0 << 3);
            aq_reg   <= a0 + QUARTER;
        end
    end

    ccpm_trig u_trig1   (.clk(clk), .en(en), .ang(a1_reg),   .sn(s1),   .cs(c1));
    ccpm_trig u_trig8   (.clk(clk), .en(en), .ang(a8_reg),   .sn(s8),   .cs(c8));
    ccpm_trig u_trig24  (.clk(clk), .en(en), .ang(a24_reg),  .sn(s24),  .cs(c24));
    ccpm_trig u_trig200 (.clk(clk), .en(en), .ang(a200_reg), .sn(s200), .cs(c200));
    ccpm_trig u_trigq   (.clk(clk), .en(en), .ang(aq_reg),   .sn(sq),   .cs(cq));

    // product pipe
    always_comb
    begin
        pr = (FW+17)'(p4_r_reg) *
             (FW+17)'($signed({1'b0, sb_reg[FRONT_LAT+3].rand_frac}));
        p5_r_next = fill_reg ? frac_t'(pr >>> 16) : p4_r_reg;

        px = (32+FW)'(weight_reg) * (32+FW)'(p6_nx_reg);
        py = (32+FW)'(weight_reg) * (32+FW)'(p6_ny_reg);
        pz = 64'(weight_reg) * 64'(sb_reg[FRONT_LAT+5].src_z);
        p7_tx_next = TW'((px + (32+FW)'(HALF_F)) >>> FRAC_BITS);
        p7_ty_next = TW'((py + (32+FW)'(HALF_F)) >>> FRAC_BITS);
        p7_tz_next = ZW'((pz + 64'sd32768) >>> 16);

        sx = (TW+1)'(sb_reg[FRONT_LAT+6].acc_x) + (TW+1)'(p7_tx_reg);
        sy = (TW+1)'(sb_reg[FRONT_LAT+6].acc_y) + (TW+1)'(p7_ty_reg);
        sz = (ZW+1)'(sb_reg[FRONT_LAT+6].acc_z) + (ZW+1)'(p7_tz_reg);
        if (sx > (TW+1)'(32'sh7FFF_FFFF))
            p8_x_next = 32'sh7FFF_FFFF;
        else if (sx < (TW+1)'(32'sh8000_0000))
            p8_x_next = 32'sh8000_0000;
        else
            p8_x_next = 32'(sx);
        if (sy > (TW+1)'(32'sh7FFF_FFFF))
            p8_y_next = 32'sh7FFF_FFFF;
        else if (sy < (TW+1)'(32'sh8000_0000))
            p8_y_next = 32'sh8000_0000;
        else
            p8_y_next = 32'(sy);
        if (sz > (ZW+1)'(32'sh7FFF_FFFF))
            p8_z_next = 32'sh7FFF_FFFF;
        else if (sz < (ZW+1)'(32'sh8000_0000))
            p8_z_next = 32'sh8000_0000;
        else
            p8_z_next = 32'(sz);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_f1_reg <= frac_t'(ONE_F) + mulr_f(frac_t'(NINE_TENTHS), frac_t'(c8));
            p1_f2_reg <= frac_t'(ONE_F) + mulr_f(frac_t'(ONE_TENTH), frac_t'(c24));
            p1_f3_reg <= frac_t'(NINE_TENTHS) + mulr_f(frac_t'(ONE_TENTH), frac_t'(c200));
            p1_f4_reg <= frac_t'(ONE_F) + frac_t'(s1);
            p1_sq_reg <= sq;
            p1_cq_reg <= cq;

            p2_m_reg  <= mulr_f(p1_f1_reg, p1_f2_reg);
            p2_f3_reg <= p1_f3_reg;
            p2_f4_reg <= p1_f4_reg;
            p2_sq_reg <= p1_sq_reg;
            p2_cq_reg <= p1_cq_reg;

            p3_m_reg  <= mulr_f(p2_m_reg, p2_f3_reg);
            p3_f4_reg <= p2_f4_reg;
            p3_sq_reg <= p2_sq_reg;
            p3_cq_reg <= p2_cq_reg;

            p4_r_reg  <= mulr_f(p3_m_reg, p3_f4_reg);
            p4_sq_reg <= p3_sq_reg;
            p4_cq_reg <= p3_cq_reg;

            p5_r_reg  <= p5_r_next;
            p5_sq_reg <= p4_sq_reg;
            p5_cq_reg <= p4_cq_reg;

            p6_nx_reg <= mulr_f(frac_t'(p5_sq_reg), p5_r_reg);
            p6_ny_reg <= mulr_f(frac_t'(p5_cq_reg), p5_r_reg);

            p7_tx_reg <= p7_tx_next;
            p7_ty_reg <= p7_ty_next;
            p7_tz_reg <= p7_tz_next;

            p8_x_reg <= p8_x_next;
            p8_y_reg <= p8_y_next;
            p8_z_reg <= p8_z_next;
        end
    end

    assign pt_out.new_x = p8_x_reg;
    assign pt_out.new_y = p8_y_reg;
    assign pt_out.new_z = p8_z_reg;

    // a stalled pipe keeps the valid line and the x and z outputs in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(p8_x_reg) && $stable(p8_z_reg))
        else $error("pipe moved during stall");

    // 1 + sin a stays within [0, 2]
    a_f4_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRONT_LAT] |-> (p1_f4_reg >= 0) && (p1_f4_reg <= frac_t'(2 * ONE_F)))
        else $error("sine factor out of range");

    // curve radius is never negative
    a_r_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRONT_LAT+3] |-> !p4_r_reg[FW-1])
        else $error("negative radius");

endmodule
